// File: hdl/cwfs_pkg.sv
// cwfs_pkg: shared types, codes and the axis clip function of the clipped
// window fill sequencer. Depends on nothing; the top level, front and back use it.
package cwfs_pkg;

    localparam int unsigned CFG_BITS   = 13;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 13'd480;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 13'd320;

    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_BEAT   = 2'd0,
        ST_REJECT = 2'd1,
        ST_IDLE   = 2'd2,
        ST_BUSY   = 2'd3
    } status_t;

    // Sequence phase: header beats in bus order, then the pixel phase.
    typedef enum logic [3:0] {
        PH_COL_CMD = 4'd0,
        PH_YLO_H   = 4'd1,
        PH_YLO_L   = 4'd2,
        PH_YHI_H   = 4'd3,
        PH_YHI_L   = 4'd4,
        PH_ROW_CMD = 4'd5,
        PH_XLO_H   = 4'd6,
        PH_XLO_L   = 4'd7,
        PH_XHI_H   = 4'd8,
        PH_XHI_L   = 4'd9,
        PH_MEM_CMD = 4'd10,
        PH_PIXEL   = 4'd11
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic        [15:0] fill_color;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic       is_command;
        logic [7:0] bus_byte;
        logic       last_beat;
    } out_item_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] lo;
        logic [15:0] hi;
    } axis_t;

    // Classified word passed from front to back.
    typedef struct packed {
        kind_t       kind;
        logic        ok;
        logic [15:0] x_lo;
        logic [15:0] x_hi;
        logic [15:0] y_lo;
        logic [15:0] y_hi;
        logic [15:0] color;
    } cmd_t;

    // Order the two ends, reject a span wholly outside 0..lim, clamp the rest.
    function automatic axis_t clip_axis(input logic signed [15:0] a,
                                        input logic signed [15:0] b,
                                        input logic [16:0] lim);
        axis_t              r;
        logic signed [15:0] s_lo;
        logic signed [15:0] s_hi;
        logic signed [17:0] l;
        logic signed [17:0] h;
        logic signed [17:0] m;
        s_lo = (a < b) ? a : b;
        s_hi = (a < b) ? b : a;
        l = {{2{s_lo[15]}}, s_lo};
        h = {{2{s_hi[15]}}, s_hi};
        m = {1'b0, lim};
        r.ok = !(l > m) && !(h < 18'sd0);
        r.lo = (l < 18'sd0) ? 16'd0 : l[15:0];
        r.hi = (h > m) ? m[15:0] : h[15:0];
        return r;
    endfunction

endpackage

// File: hdl/clipped_window_fill_sequencer.sv
// clipped_window_fill_sequencer: top level; classifier front, command queue,
// beat sequencer back and result queue. Depends on cwfs_pkg, cwfs_front,
// cwfs_queue and cwfs_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  request   | push / full          | item   (kind, corners, fill_color)
//  result    | pop / empty          | result (status, is_command, bus_byte,
//            |                      |         last_beat)
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data (screen size)
//
// One word in and one word out per cycle when neither side stalls; the result
// of a word passes from the command queue, whose head the sequencer works
// straight off, into the result queue, from which the consumer pops it.
// Rate is set by the sequencer, which handles one word per cycle while the result queue has room.
// Reset (rst_n low) empties both queues, idles the sequencer and loads the
// screen size to 480 by 320. When pop is held off the result queue fills,
// the sequencer holds, the command queue fills and full rises.
module clipped_window_fill_sequencer #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  cwfs_pkg::in_item_t                 item,
    output logic                               empty,
    input  logic                               pop,
    output cwfs_pkg::out_item_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cwfs_pkg::CFG_BITS-1:0]      cfg_data
);
    localparam int unsigned CmdBits = $bits(cwfs_pkg::cmd_t);
    localparam int unsigned OutBits = $bits(cwfs_pkg::out_item_t);

    cwfs_pkg::cmd_t      cmd_in, cmd_out;
    cwfs_pkg::out_item_t out_word;
    logic [CmdBits-1:0]  cmd_rdata;
    logic [OutBits-1:0]  out_rdata;
    logic                cmd_empty, cmd_pop;
    logic                out_full, out_push;

    // Classify the incoming word against the current screen size.
    cwfs_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd_in)
    );

    // Decouple the front from the sequencer.
    cwfs_queue #(.WIDTH(CmdBits)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign cmd_out = cwfs_pkg::cmd_t'(cmd_rdata);

    // Advance the window state and build one result word per command word.
    cwfs_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_room  (!out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    // Hold finished words until the consumer pops them.
    cwfs_queue #(.WIDTH(OutBits)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = cwfs_pkg::out_item_t'(out_rdata);

endmodule

// File: hdl/cwfs_queue.sv
// cwfs_queue: two-entry first-in first-out queue of words.
// Depends on nothing; used between front and back and on the result side.
module cwfs_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int unsigned DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/cwfs_front.sv
// cwfs_front: screen size registers and request classification (order, clip,
// off-screen check). Depends on cwfs_pkg.
module cwfs_front #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cwfs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cwfs_pkg::CFG_BITS-1:0]        cfg_data,
    input  cwfs_pkg::in_item_t                   item,
    output cwfs_pkg::cmd_t                       cmd
);
    localparam logic [16:0] CoordMax = 17'((32'd1 << COORD_BITS) - 32'd1);

    logic [cwfs_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic [16:0]                   x_lim, y_lim;
    logic [cwfs_pkg::CFG_BITS-1:0] x_m, y_m;
    cwfs_pkg::axis_t               ax, ay;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cwfs_pkg::SCREEN_WIDTH_RST;
            height_reg <= cwfs_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cwfs_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                cwfs_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one; cap the limit at the largest coordinate.
    always_comb
    begin
        x_m   = (width_reg == '0) ? '0 : width_reg - 13'd1;
        y_m   = (height_reg == '0) ? '0 : height_reg - 13'd1;
        x_lim = ({4'd0, x_m} > CoordMax) ? CoordMax : {4'd0, x_m};
        y_lim = ({4'd0, y_m} > CoordMax) ? CoordMax : {4'd0, y_m};
        ax    = cwfs_pkg::clip_axis(item.x_start, item.x_end, x_lim);
        ay    = cwfs_pkg::clip_axis(item.y_start, item.y_end, y_lim);
    end

    always_comb
    begin
        cmd.kind  = cwfs_pkg::kind_t'(item.kind);
        cmd.ok    = ax.ok && ay.ok;
        cmd.x_lo  = ax.lo;
        cmd.x_hi  = ax.hi;
        cmd.y_lo  = ay.lo;
        cmd.y_hi  = ay.hi;
        cmd.color = item.fill_color;
    end

endmodule

// File: hdl/cwfs_back.sv
// cwfs_back: window state and beat sequencer; turns classified words into
// result words. Depends on cwfs_pkg.
module cwfs_back #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cwfs_pkg::cmd_t       cmd,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  logic                 out_room,
    output logic                 out_push,
    output cwfs_pkg::out_item_t  out_word
);
    logic                   active_reg, active_next;
    cwfs_pkg::phase_t       phase_reg, phase_next;
    logic [COORD_BITS-1:0]  x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic [COORD_BITS-1:0]  y_lo_reg, y_lo_next, y_hi_reg, y_hi_next;
    logic [COORD_BITS-1:0]  cols_reg, cols_next, rows_reg, rows_next;
    logic [15:0]            color_reg, color_next;
    logic                   low_reg, low_next;
    logic                   fire, is_req, take_req, step;
    logic [15:0]            x_lo16, x_hi16, y_lo16, y_hi16;

    assign fire     = cmd_valid && out_room;
    assign cmd_pop  = fire;
    assign out_push = fire;
    assign is_req   = (cmd.kind == cwfs_pkg::KIND_REQUEST);
    assign take_req = fire && is_req && !active_reg && cmd.ok;
    assign step     = fire && !is_req && active_reg;

    assign x_lo16 = 16'(x_lo_reg);
    assign x_hi16 = 16'(x_hi_reg);
    assign y_lo16 = 16'(y_lo_reg);
    assign y_hi16 = 16'(y_hi_reg);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (take_req)
        begin
            phase_next = cwfs_pkg::PH_COL_CMD;
        end
        else if (step)
        begin
            case (phase_reg)
                cwfs_pkg::PH_PIXEL:
                begin
                    if (low_reg && cols_reg == '0 && rows_reg == '0)
                    begin
                        phase_next = cwfs_pkg::PH_COL_CMD;
                    end
                end
                default: phase_next = cwfs_pkg::phase_t'(phase_reg + 4'd1);
            endcase
        end
    end

    // Window and counters.
    always_comb
    begin
        active_next = active_reg;
        x_lo_next   = x_lo_reg;
        x_hi_next   = x_hi_reg;
        y_lo_next   = y_lo_reg;
        y_hi_next   = y_hi_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        color_next  = color_reg;
        low_next    = low_reg;
        if (take_req)
        begin
            active_next = 1'b1;
            x_lo_next   = cmd.x_lo[COORD_BITS-1:0];
            x_hi_next   = cmd.x_hi[COORD_BITS-1:0];
            y_lo_next   = cmd.y_lo[COORD_BITS-1:0];
            y_hi_next   = cmd.y_hi[COORD_BITS-1:0];
            cols_next   = cmd.x_hi[COORD_BITS-1:0] - cmd.x_lo[COORD_BITS-1:0];
            rows_next   = cmd.y_hi[COORD_BITS-1:0] - cmd.y_lo[COORD_BITS-1:0];
            color_next  = cmd.color;
            low_next    = 1'b0;
        end
        else if (step && phase_reg == cwfs_pkg::PH_PIXEL)
        begin
            low_next = !low_reg;
            if (low_reg)
            begin
                if (cols_reg != '0)
                begin
                    cols_next = cols_reg - COORD_BITS'(1);
                end
                else if (rows_reg != '0)
                begin
                    rows_next = rows_reg - COORD_BITS'(1);
                    cols_next = x_hi_reg - x_lo_reg;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // Result word.
    always_comb
    begin
        out_word            = '0;
        out_word.status     = cwfs_pkg::ST_IDLE;
        if (is_req)
        begin
            if (active_reg)
            begin
                out_word.status = cwfs_pkg::ST_BUSY;
            end
            else if (!cmd.ok)
            begin
                out_word.status = cwfs_pkg::ST_REJECT;
            end
        end
        else if (active_reg)
        begin
            out_word.status = cwfs_pkg::ST_BEAT;
            case (phase_reg)
                cwfs_pkg::PH_COL_CMD:
                begin
                    out_word.is_command = 1'b1;
                    out_word.bus_byte   = cwfs_pkg::CMD_COL_SET;
                end
                cwfs_pkg::PH_YLO_H:   out_word.bus_byte = y_lo16[15:8];
                cwfs_pkg::PH_YLO_L:   out_word.bus_byte = y_lo16[7:0];
                cwfs_pkg::PH_YHI_H:   out_word.bus_byte = y_hi16[15:8];
                cwfs_pkg::PH_YHI_L:   out_word.bus_byte = y_hi16[7:0];
                cwfs_pkg::PH_ROW_CMD:
                begin
                    out_word.is_command = 1'b1;
                    out_word.bus_byte   = cwfs_pkg::CMD_ROW_SET;
                end
                cwfs_pkg::PH_XLO_H:   out_word.bus_byte = x_lo16[15:8];
                cwfs_pkg::PH_XLO_L:   out_word.bus_byte = x_lo16[7:0];
                cwfs_pkg::PH_XHI_H:   out_word.bus_byte = x_hi16[15:8];
                cwfs_pkg::PH_XHI_L:   out_word.bus_byte = x_hi16[7:0];
                cwfs_pkg::PH_MEM_CMD:
                begin
                    out_word.is_command = 1'b1;
                    out_word.bus_byte   = cwfs_pkg::CMD_MEM_WRITE;
                end
                default:
                begin
                    out_word.bus_byte  = low_reg ? color_reg[7:0] : color_reg[15:8];
                    out_word.last_beat = low_reg && cols_reg == '0 && rows_reg == '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= cwfs_pkg::PH_COL_CMD;
            low_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            low_reg    <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_lo_reg  <= x_lo_next;
        x_hi_reg  <= x_hi_next;
        y_lo_reg  <= y_lo_next;
        y_hi_reg  <= y_hi_next;
        cols_reg  <= cols_next;
        rows_reg  <= rows_next;
        color_reg <= color_next;
    end

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_word.last_beat) |=> !active_reg)
        else $error("sequence still active after last beat");

    a_busy_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_word.status == cwfs_pkg::ST_BUSY) |-> active_reg)
        else $error("busy reported while idle");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (phase_reg == cwfs_pkg::PH_COL_CMD && !low_reg))
        else $error("sequencer idle with stale phase");

    a_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (out_push && cmd_valid))
        else $error("word dropped between queues");

endmodule
